// ===== sv/lripf_pkg.sv =====
// Shared types, widths, register indexes and reset values for the lidar
// range and intensity point filter. No dependencies.
package lripf_pkg;

   // point coordinate width
   localparam int COORD_BITS = 24;
   localparam int SQ_BITS    = 2 * COORD_BITS;
   localparam int SUM_BITS   = SQ_BITS + 2;

   localparam int RANGE_BITS     = 20;
   localparam int THR_SQ_BITS    = 2 * RANGE_BITS;
   localparam int INT_BITS       = 16;
   localparam int INT_THR_BITS   = 17;
   localparam int MODE_BITS      = 5;
   localparam int FILL_BITS      = 24;
   localparam int CSR_DATA_BITS  = 24;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CMP_BITS = (SUM_BITS > THR_SQ_BITS) ? SUM_BITS : THR_SQ_BITS;

   typedef logic signed [COORD_BITS-1:0]   coord_type;
   typedef logic        [COORD_BITS-1:0]   mag_type;
   typedef logic        [SQ_BITS-1:0]      sq_type;
   typedef logic        [SUM_BITS-1:0]     sum_type;
   typedef logic        [CMP_BITS-1:0]     cmp_type;
   typedef logic        [RANGE_BITS-1:0]   range_type;
   typedef logic        [THR_SQ_BITS-1:0]  thr_sq_type;
   typedef logic        [INT_BITS-1:0]     int_type;
   typedef logic        [INT_THR_BITS-1:0] int_thr_type;
   typedef logic        [MODE_BITS-1:0]    mode_type;
   typedef logic signed [FILL_BITS-1:0]    fill_type;
   typedef logic        [CSR_DATA_BITS-1:0]  csr_data_type;
   typedef logic        [CSR_INDEX_BITS-1:0] csr_index_type;

   // register indexes
   localparam csr_index_type CSR_RANGE_MIN     = 3'd0;
   localparam csr_index_type CSR_RANGE_MAX     = 3'd1;
   localparam csr_index_type CSR_INT_THRESHOLD = 3'd2;
   localparam csr_index_type CSR_INT_RANGE     = 3'd3;
   localparam csr_index_type CSR_MODE          = 3'd4;
   localparam csr_index_type CSR_INVALID_FILL  = 3'd5;

   // mode bit positions
   localparam int MODE_CLIP       = 0;
   localparam int MODE_INTENSITY  = 1;
   localparam int MODE_KEEP_CLOSE = 2;
   localparam int MODE_KEEP_FAR   = 3;
   localparam int MODE_KEEP_LOW   = 4;

   // reset values
   localparam range_type   RANGE_MIN_RST     = 20'd400;
   localparam range_type   RANGE_MAX_RST     = 20'd100000;
   localparam int_thr_type INT_THRESHOLD_RST = 17'd65536;
   localparam range_type   INT_RANGE_RST     = 20'd1048575;
   localparam mode_type    MODE_RST          = 5'd0;
   localparam fill_type    INVALID_FILL_RST  = 24'sh800000;

   localparam thr_sq_type RANGE_MIN_SQ_RST =
      THR_SQ_BITS'(RANGE_MIN_RST) * THR_SQ_BITS'(RANGE_MIN_RST);
   localparam thr_sq_type RANGE_MAX_SQ_RST =
      THR_SQ_BITS'(RANGE_MAX_RST) * THR_SQ_BITS'(RANGE_MAX_RST);
   localparam thr_sq_type INT_RANGE_SQ_RST =
      THR_SQ_BITS'(INT_RANGE_RST) * THR_SQ_BITS'(INT_RANGE_RST);

endpackage

// ===== sv/lripf_req_if.sv =====
// Request channel of the lidar point filter: one point per request.
// Depends on lripf_pkg.
interface lripf_req_if;
   logic                valid;
   logic                ready;
   lripf_pkg::coord_type x_mm;
   lripf_pkg::coord_type y_mm;
   lripf_pkg::coord_type z_mm;
   lripf_pkg::range_type measured_range_mm;
   lripf_pkg::int_type   intensity;
   logic                has_range;
   logic                has_intensity;
   logic                last_point;

   modport source (
      output valid, x_mm, y_mm, z_mm, measured_range_mm, intensity,
             has_range, has_intensity, last_point,
      input  ready
   );
   modport sink (
      input  valid, x_mm, y_mm, z_mm, measured_range_mm, intensity,
             has_range, has_intensity, last_point,
      output ready
   );
endinterface

// ===== sv/lripf_rsp_if.sv =====
// Result channel of the lidar point filter: one filtered point per request.
// Depends on lripf_pkg.
interface lripf_rsp_if;
   logic                valid;
   logic                ready;
   lripf_pkg::coord_type x_out;
   lripf_pkg::coord_type y_out;
   lripf_pkg::coord_type z_out;
   logic                too_close;
   logic                too_far;
   logic                low_intensity;
   logic                keep_removed;
   logic                last_out;

   modport source (
      output valid, x_out, y_out, z_out, too_close, too_far, low_intensity,
             keep_removed, last_out,
      input  ready
   );
   modport sink (
      input  valid, x_out, y_out, z_out, too_close, too_far, low_intensity,
             keep_removed, last_out,
      output ready
   );
endinterface

// ===== sv/lidar_range_intensity_point_filter.sv =====
// Lidar range and intensity point filter: flags near, far and weak points
// and replaces their coordinates. Depends on lripf_pkg, lripf_req_if, lripf_rsp_if.
// Pipeline: two register stages; the squares are registered when the request is accepted,
// and the sum, compares and fill are registered into the result registers behind them.
// Throughput: one request per cycle; stalls only when the result is not taken.
// Reset: synchronous; clears both pipeline valids and reloads register defaults.
module lidar_range_intensity_point_filter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  lripf_pkg::csr_index_type   csr_index,
   input  lripf_pkg::csr_data_type    csr_wdata,
   lripf_req_if.sink                  req_bus,
   lripf_rsp_if.source                rsp_bus
);

   // configuration registers
   lripf_pkg::range_type   range_min_ff, range_min_in;
   lripf_pkg::range_type   range_max_ff, range_max_in;
   lripf_pkg::int_thr_type int_thr_ff, int_thr_in;
   lripf_pkg::range_type   int_range_ff, int_range_in;
   lripf_pkg::mode_type    mode_ff, mode_in;
   lripf_pkg::fill_type    fill_ff, fill_in;
   lripf_pkg::thr_sq_type  range_min_sq_ff, range_min_sq_in;
   lripf_pkg::thr_sq_type  range_max_sq_ff, range_max_sq_in;
   lripf_pkg::thr_sq_type  int_range_sq_ff, int_range_sq_in;
   lripf_pkg::range_type   wr_range;
   lripf_pkg::thr_sq_type  wr_range_sq;

   assign wr_range    = csr_wdata[lripf_pkg::RANGE_BITS-1:0];
   assign wr_range_sq = lripf_pkg::thr_sq_type'(wr_range)
                      * lripf_pkg::thr_sq_type'(wr_range);

   always_comb begin
      range_min_in    = range_min_ff;
      range_max_in    = range_max_ff;
      int_thr_in      = int_thr_ff;
      int_range_in    = int_range_ff;
      mode_in         = mode_ff;
      fill_in         = fill_ff;
      range_min_sq_in = range_min_sq_ff;
      range_max_sq_in = range_max_sq_ff;
      int_range_sq_in = int_range_sq_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            lripf_pkg::CSR_RANGE_MIN: begin
               range_min_in    = wr_range;
               range_min_sq_in = wr_range_sq;
            end
            lripf_pkg::CSR_RANGE_MAX: begin
               range_max_in    = wr_range;
               range_max_sq_in = wr_range_sq;
            end
            lripf_pkg::CSR_INT_THRESHOLD: begin
               int_thr_in = csr_wdata[lripf_pkg::INT_THR_BITS-1:0];
            end
            lripf_pkg::CSR_INT_RANGE: begin
               int_range_in    = wr_range;
               int_range_sq_in = wr_range_sq;
            end
            lripf_pkg::CSR_MODE: begin
               mode_in = csr_wdata[lripf_pkg::MODE_BITS-1:0];
            end
            lripf_pkg::CSR_INVALID_FILL: begin
               fill_in = lripf_pkg::fill_type'(csr_wdata[lripf_pkg::FILL_BITS-1:0]);
            end
            default: begin
               // unknown index: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff    <= lripf_pkg::RANGE_MIN_RST;
         range_max_ff    <= lripf_pkg::RANGE_MAX_RST;
         int_thr_ff      <= lripf_pkg::INT_THRESHOLD_RST;
         int_range_ff    <= lripf_pkg::INT_RANGE_RST;
         mode_ff         <= lripf_pkg::MODE_RST;
         fill_ff         <= lripf_pkg::INVALID_FILL_RST;
         range_min_sq_ff <= lripf_pkg::RANGE_MIN_SQ_RST;
         range_max_sq_ff <= lripf_pkg::RANGE_MAX_SQ_RST;
         int_range_sq_ff <= lripf_pkg::INT_RANGE_SQ_RST;
      end else begin
         range_min_ff    <= range_min_in;
         range_max_ff    <= range_max_in;
         int_thr_ff      <= int_thr_in;
         int_range_ff    <= int_range_in;
         mode_ff         <= mode_in;
         fill_ff         <= fill_in;
         range_min_sq_ff <= range_min_sq_in;
         range_max_sq_ff <= range_max_sq_in;
         int_range_sq_ff <= int_range_sq_in;
      end
   end

   // pipeline control
   logic s1_vld_ff, s1_vld_in;
   logic out_vld_ff, out_vld_in;
   logic out_adv, s1_adv, req_acc;

   assign out_adv       = !out_vld_ff || rsp_bus.ready;
   assign s1_adv        = !s1_vld_ff || out_adv;
   assign req_bus.ready = s1_adv;
   assign req_acc       = req_bus.valid && s1_adv;
   assign s1_vld_in     = s1_adv ? req_bus.valid : s1_vld_ff;
   assign out_vld_in    = out_adv ? s1_vld_ff : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // stage 1: coordinate magnitudes squared
   lripf_pkg::mag_type mag_x, mag_y, mag_z;
   lripf_pkg::mag_type raw_x, raw_y, raw_z;
   lripf_pkg::sq_type  sq_x_in, sq_y_in, sq_z_in;
   lripf_pkg::sq_type  sq_x_ff, sq_y_ff, sq_z_ff;
   lripf_pkg::coord_type x_ff, y_ff, z_ff;
   lripf_pkg::range_type meas_ff;
   lripf_pkg::int_type   inten_ff;
   logic has_range_ff, has_int_ff, last_ff;

   assign raw_x = lripf_pkg::mag_type'(req_bus.x_mm);
   assign raw_y = lripf_pkg::mag_type'(req_bus.y_mm);
   assign raw_z = lripf_pkg::mag_type'(req_bus.z_mm);
   assign mag_x = raw_x[lripf_pkg::COORD_BITS-1] ? (~raw_x + lripf_pkg::mag_type'(1)) : raw_x;
   assign mag_y = raw_y[lripf_pkg::COORD_BITS-1] ? (~raw_y + lripf_pkg::mag_type'(1)) : raw_y;
   assign mag_z = raw_z[lripf_pkg::COORD_BITS-1] ? (~raw_z + lripf_pkg::mag_type'(1)) : raw_z;
   assign sq_x_in = lripf_pkg::sq_type'(mag_x) * lripf_pkg::sq_type'(mag_x);
   assign sq_y_in = lripf_pkg::sq_type'(mag_y) * lripf_pkg::sq_type'(mag_y);
   assign sq_z_in = lripf_pkg::sq_type'(mag_z) * lripf_pkg::sq_type'(mag_z);

   always_ff @(posedge clock) begin
      if (req_acc) begin
         sq_x_ff      <= sq_x_in;
         sq_y_ff      <= sq_y_in;
         sq_z_ff      <= sq_z_in;
         x_ff         <= req_bus.x_mm;
         y_ff         <= req_bus.y_mm;
         z_ff         <= req_bus.z_mm;
         meas_ff      <= req_bus.measured_range_mm;
         inten_ff     <= req_bus.intensity;
         has_range_ff <= req_bus.has_range;
         has_int_ff   <= req_bus.has_intensity;
         last_ff      <= req_bus.last_point;
      end
   end

   // stage 2: squared norm, compares and fill
   lripf_pkg::sum_type   norm_sq;
   lripf_pkg::cmp_type   norm_cmp;
   lripf_pkg::coord_type fill_coord;
   logic clip_on, int_on, near_int;
   logic close_in, far_in, low_in, keep_in, removed;
   lripf_pkg::coord_type x_out_in, y_out_in, z_out_in;

   assign norm_sq = lripf_pkg::sum_type'(sq_x_ff) + lripf_pkg::sum_type'(sq_y_ff)
                  + lripf_pkg::sum_type'(sq_z_ff);
   assign norm_cmp   = lripf_pkg::cmp_type'(norm_sq);
   assign fill_coord = lripf_pkg::coord_type'(fill_ff);
   assign clip_on    = mode_ff[lripf_pkg::MODE_CLIP];
   assign int_on     = mode_ff[lripf_pkg::MODE_INTENSITY] && has_int_ff;

   always_comb begin
      if (has_range_ff) begin
         close_in = clip_on && (meas_ff < range_min_ff);
         far_in   = clip_on && (meas_ff > range_max_ff);
         near_int = meas_ff < int_range_ff;
      end else begin
         close_in = clip_on && (norm_cmp < lripf_pkg::cmp_type'(range_min_sq_ff));
         far_in   = clip_on && (norm_cmp > lripf_pkg::cmp_type'(range_max_sq_ff));
         near_int = norm_cmp < lripf_pkg::cmp_type'(int_range_sq_ff);
      end
      low_in  = int_on && near_int
             && (lripf_pkg::int_thr_type'(inten_ff) < int_thr_ff);
      keep_in = (close_in && mode_ff[lripf_pkg::MODE_KEEP_CLOSE])
             || (far_in && mode_ff[lripf_pkg::MODE_KEEP_FAR])
             || (low_in && mode_ff[lripf_pkg::MODE_KEEP_LOW]);
      removed  = close_in || far_in || low_in;
      x_out_in = removed ? fill_coord : x_ff;
      y_out_in = removed ? fill_coord : y_ff;
      z_out_in = removed ? fill_coord : z_ff;
   end

   lripf_pkg::coord_type x_out_ff, y_out_ff, z_out_ff;
   logic close_ff, far_ff, low_ff, keep_ff, last_out_ff;

   always_ff @(posedge clock) begin
      if (out_adv && s1_vld_ff) begin
         x_out_ff    <= x_out_in;
         y_out_ff    <= y_out_in;
         z_out_ff    <= z_out_in;
         close_ff    <= close_in;
         far_ff      <= far_in;
         low_ff      <= low_in;
         keep_ff     <= keep_in;
         last_out_ff <= last_ff;
      end
   end

   assign rsp_bus.valid         = out_vld_ff;
   assign rsp_bus.x_out         = x_out_ff;
   assign rsp_bus.y_out         = y_out_ff;
   assign rsp_bus.z_out         = z_out_ff;
   assign rsp_bus.too_close     = close_ff;
   assign rsp_bus.too_far       = far_ff;
   assign rsp_bus.low_intensity = low_ff;
   assign rsp_bus.keep_removed  = keep_ff;
   assign rsp_bus.last_out      = last_out_ff;

   // a flagged point carries the fill in every coordinate
   a_fill_on_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.too_close || rsp_bus.too_far || rsp_bus.low_intensity))
      |-> (rsp_bus.x_out == fill_coord && rsp_bus.y_out == fill_coord
           && rsp_bus.z_out == fill_coord))
      else $error("removed point without fill coordinates");

   a_keep_needs_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.keep_removed)
      |-> (rsp_bus.too_close || rsp_bus.too_far || rsp_bus.low_intensity))
      else $error("keep_removed set on a point that was not removed");

   a_clip_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !mode_ff[lripf_pkg::MODE_CLIP])
      |-> (!rsp_bus.too_close && !rsp_bus.too_far))
      else $error("range flag set with range clip disabled");

   // a stalled result must not let the middle stage drop its request
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && rsp_bus.valid && !rsp_bus.ready) |=> s1_vld_ff)
      else $error("stage 1 request lost under result stall");

endmodule
